[design/seqtr_pkg.sv]
// Package for the sequenced event trace ring.
// Holds the item types, record layout, request codes and the
// command and status structs between the controller and the datapath.
package seqtr_pkg;

   localparam int DEFAULT_RING_DEPTH = 16;
   localparam int LIMIT_W            = 7;
   localparam int SEQ_W              = 64;

   localparam logic REQ_WRITE    = 1'b0;
   localparam logic REQ_SNAPSHOT = 1'b1;

   typedef struct packed {
      logic               req_type;
      logic [63:0]        event_time;
      logic [7:0]         event_kind;
      logic [31:0]        subject_ident;
      logic [31:0]        actor_ident;
      logic signed [31:0] result_code;
      logic [63:0]        payload_a;
      logic [63:0]        payload_b;
      logic [LIMIT_W-1:0] out_limit;
   } req_item_type;

   typedef struct packed {
      logic               valid_res;
      logic [SEQ_W-1:0]   out_seq;
      logic [63:0]        out_time;
      logic [7:0]         out_kind;
      logic [31:0]        out_subject;
      logic [31:0]        out_actor;
      logic signed [31:0] out_code;
      logic [63:0]        out_payload_a;
      logic [63:0]        out_payload_b;
      logic               last;
   } rsp_item_type;

   typedef struct packed {
      logic [SEQ_W-1:0]   seq;
      logic [63:0]        time_stamp;
      logic [7:0]         kind;
      logic [31:0]        subject;
      logic [31:0]        actor;
      logic signed [31:0] code;
      logic [63:0]        payload_a;
      logic [63:0]        payload_b;
   } slot_rec_type;

   typedef struct packed {
      logic write_en;
      logic snap_start;
      logic fetch;
   } seqtr_cmd_type;

   typedef struct packed {
      logic last_fetch;
   } seqtr_status_type;

endpackage

[design/seqtr_datapath.sv]
// Datapath of the sequenced event trace ring: record memory, sequence
// counter, write and read pointers, fill count and the output register.
// Depends on seqtr_pkg; driven by commands from seqtr_controller.
module seqtr_datapath
   import seqtr_pkg::*;
#(
   parameter int RING_DEPTH = DEFAULT_RING_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  req_item_type     req_item,
   input  seqtr_cmd_type    cmd,
   output seqtr_status_type status,
   output rsp_item_type     rsp_item
);

   localparam int IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CNT_W = $clog2(RING_DEPTH + 1);
   localparam int SUM_W = IDX_W + 1;

   slot_rec_type slot_mem [RING_DEPTH];

   logic [SEQ_W-1:0] seq_stamp_ff, seq_stamp_in;
   logic [IDX_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] remain_ff, remain_in;
   logic [IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   rsp_item_type     out_ff;

   logic [CNT_W-1:0] snap_count;
   logic [SUM_W-1:0] start_sum;
   logic [IDX_W-1:0] start_ptr;
   slot_rec_type     wr_rec;
   rsp_item_type     term_item;

   function automatic logic [IDX_W-1:0] ptr_next(input logic [IDX_W-1:0] p);
      logic [IDX_W-1:0] r;
      if (p == IDX_W'(RING_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + IDX_W'(1);
      end
      return r;
   endfunction

   always_comb begin
      if (LIMIT_W'(fill_ff) <= req_item.out_limit) begin
         snap_count = fill_ff;
      end else begin
         snap_count = req_item.out_limit[CNT_W-1:0];
      end
      start_sum = SUM_W'(wr_ptr_ff) + SUM_W'(RING_DEPTH) - SUM_W'(snap_count);
      if (start_sum >= SUM_W'(RING_DEPTH)) begin
         start_ptr = IDX_W'(start_sum - SUM_W'(RING_DEPTH));
      end else begin
         start_ptr = IDX_W'(start_sum);
      end
   end

   always_comb begin
      wr_rec.seq        = seq_stamp_ff;
      wr_rec.time_stamp = req_item.event_time;
      wr_rec.kind       = req_item.event_kind;
      wr_rec.subject    = req_item.subject_ident;
      wr_rec.actor      = req_item.actor_ident;
      wr_rec.code       = req_item.result_code;
      wr_rec.payload_a  = req_item.payload_a;
      wr_rec.payload_b  = req_item.payload_b;
   end

   always_comb begin
      term_item      = '0;
      term_item.last = 1'b1;
   end

   always_comb begin
      seq_stamp_in = seq_stamp_ff;
      wr_ptr_in    = wr_ptr_ff;
      fill_in      = fill_ff;
      remain_in    = remain_ff;
      rd_ptr_in    = rd_ptr_ff;
      if (cmd.write_en) begin
         seq_stamp_in = seq_stamp_ff + SEQ_W'(1);
         wr_ptr_in    = ptr_next(wr_ptr_ff);
         // When the counter has wrapped to 0, the fill count is cleared, so no earlier record qualifies.
         if (seq_stamp_ff == '0) begin
            fill_in = '0;
         end else if (fill_ff != CNT_W'(RING_DEPTH)) begin
            fill_in = fill_ff + CNT_W'(1);
         end
      end
      if (cmd.snap_start) begin
         remain_in = snap_count;
         rd_ptr_in = start_ptr;
      end else if (cmd.fetch && remain_ff != '0) begin
         remain_in = remain_ff - CNT_W'(1);
         rd_ptr_in = ptr_next(rd_ptr_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_stamp_ff <= SEQ_W'(1);
         wr_ptr_ff    <= '0;
         fill_ff      <= '0;
         remain_ff    <= '0;
         rd_ptr_ff    <= '0;
      end else begin
         seq_stamp_ff <= seq_stamp_in;
         wr_ptr_ff    <= wr_ptr_in;
         fill_ff      <= fill_in;
         remain_ff    <= remain_in;
         rd_ptr_ff    <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_en) begin
         slot_mem[wr_ptr_ff] <= wr_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         if (remain_ff == '0) begin
            out_ff <= term_item;
         end else begin
            out_ff.valid_res     <= 1'b1;
            out_ff.out_seq       <= slot_mem[rd_ptr_ff].seq;
            out_ff.out_time      <= slot_mem[rd_ptr_ff].time_stamp;
            out_ff.out_kind      <= slot_mem[rd_ptr_ff].kind;
            out_ff.out_subject   <= slot_mem[rd_ptr_ff].subject;
            out_ff.out_actor     <= slot_mem[rd_ptr_ff].actor;
            out_ff.out_code      <= slot_mem[rd_ptr_ff].code;
            out_ff.out_payload_a <= slot_mem[rd_ptr_ff].payload_a;
            out_ff.out_payload_b <= slot_mem[rd_ptr_ff].payload_b;
            out_ff.last          <= (remain_ff == CNT_W'(1));
         end
      end
   end

   assign status.last_fetch = (remain_ff <= CNT_W'(1));
   assign rsp_item          = out_ff;

endmodule

[design/seqtr_controller.sv]
// Controller of the sequenced event trace ring: input handshake, snapshot
// sequencing and the result valid flag.
// Depends on seqtr_pkg; commands seqtr_datapath.
module seqtr_controller
   import seqtr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_type,
   output logic             req_stall,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   input  seqtr_status_type status,
   output seqtr_cmd_type    cmd
);

   localparam logic [0:0] ST_IDLE = 1'b0;
   localparam logic [0:0] ST_RUN  = 1'b1;

   logic [0:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       req_acc;
   logic       out_free;

   always_comb begin
      req_stall      = (state_ff != ST_IDLE);
      req_acc        = req_valid && !req_stall;
      out_free       = !rsp_valid_ff || !rsp_stall;
      cmd.write_en   = req_acc && (req_type == REQ_WRITE);
      cmd.snap_start = req_acc && (req_type == REQ_SNAPSHOT);
      cmd.fetch      = (state_ff == ST_RUN) && out_free;
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (cmd.fetch) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (cmd.snap_start) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (cmd.fetch && status.last_fetch) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_snap_enters_run: assert property (@(posedge clock) disable iff (reset)
      cmd.snap_start |=> state_ff == ST_RUN)
      else $error("snapshot accepted but controller did not start readout");

   a_fetch_needs_free_output: assert property (@(posedge clock) disable iff (reset)
      cmd.fetch |-> (!rsp_valid_ff || !rsp_stall))
      else $error("fetch would overwrite an item not yet taken");

   a_last_fetch_ends_run: assert property (@(posedge clock) disable iff (reset)
      (cmd.fetch && status.last_fetch) |=> (state_ff == ST_IDLE && rsp_valid_ff))
      else $error("readout did not end after its final item");

   a_no_write_during_run: assert property (@(posedge clock) disable iff (reset)
      cmd.write_en |-> (state_ff == ST_IDLE && !cmd.fetch))
      else $error("record written while a snapshot is being read");

endmodule

[design/sequenced_event_trace_ring_unit.sv]
// Sequenced event trace ring. Write items store a record stamped with a
// running sequence number that starts at 1 after reset; a snapshot item
// reads back the newest min(written, RING_DEPTH, out_limit) records,
// oldest first, with last set on the final one. A snapshot with nothing
// to return yields one item with valid_res low and last high.
// Both channels use valid and stall; an item moves on a clock edge where
// valid is high and stall is low. A write item is taken at once and
// writes may follow back to back. A snapshot holds req_stall high while
// it runs: acceptance loads the read pointer and count, and readout goes
// on at one result item per cycle while the output register is free,
// set by the single read port of the record memory. The input side is
// free again in the cycle after the final item is read, while that item
// may still wait in the output register. When rsp_stall is high the
// output register holds its item and readout pauses. Synchronous reset
// sets the sequence number to 1, empties the ring and drops any pending
// result; memory is not cleared, as only written slots are ever read.
module sequenced_event_trace_ring_unit
   import seqtr_pkg::*;
#(
   parameter int RING_DEPTH = DEFAULT_RING_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item
);

   seqtr_cmd_type    cmd;
   seqtr_status_type status;

   seqtr_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_item.req_type),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   seqtr_datapath #(
      .RING_DEPTH (RING_DEPTH)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_item (req_item),
      .cmd      (cmd),
      .status   (status),
      .rsp_item (rsp_item)
   );

endmodule
